FILE: hw/rtl/sspr_pkg.sv
// ----------------------------------------------------------------------------
// sspr_pkg
// shared types, codes and the crc byte step of the status packet receiver
// ----------------------------------------------------------------------------
package sspr_pkg;

  // packet status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_TOO_SHORT = 3'd4
  } pkt_status_e;

  localparam int unsigned MAX_PACKET_BYTES = 128;
  localparam int unsigned MAX_SERVO_ID     = 16;
  localparam int unsigned MASK_W           = 16;

  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [15:0] MASK_RESET   = 16'h00FF;
  localparam logic [23:0] HDR_WINDOW   = 24'hFFFFFD;
  localparam logic [7:0]  HDR_LAST     = 8'h00;
  localparam logic [15:0] MIN_BODY_LEN = 16'd3;

  // byte positions inside a packet, header starts at 0
  localparam int unsigned POS_FIRST  = 4;
  localparam int unsigned POS_ID     = 4;
  localparam int unsigned POS_LEN_LO = 5;
  localparam int unsigned POS_LEN_HI = 6;
  localparam int unsigned POS_INS    = 7;
  localparam int unsigned POS_ERR    = 8;
  // header plus id plus length field
  localparam int unsigned PKT_OVERHEAD = 7;

  // one crc-16 byte step, msb first, no reflection
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc after the four header bytes
  localparam logic [15:0] CRC_HDR =
    crc_feed(crc_feed(crc_feed(crc_feed(16'h0000, 8'hFF), 8'hFF), 8'hFD), 8'h00);

  typedef struct packed {
    pkt_status_e         status;
    logic [7:0]          servo_id;
    logic [7:0]          instruction;
    logic [7:0]          servo_error;
    logic                newly_present;
    logic [MASK_W-1:0]   present_mask;
  } result_t;

endpackage

FILE: hw/rtl/sspr_out_buf.sv
// ----------------------------------------------------------------------------
// sspr_out_buf
// result register with a skid stage so upstream stall is a registered signal
// ----------------------------------------------------------------------------
module sspr_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sspr_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output sspr_pkg::result_t data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  sspr_pkg::result_t out_q;
  sspr_pkg::result_t skid_q;
  logic              take;

  assign take = out_valid_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

FILE: hw/rtl/servo_status_packet_receiver.sv
// ----------------------------------------------------------------------------
// servo_status_packet_receiver
// deframes status packets from a half-duplex servo bus byte stream
// ----------------------------------------------------------------------------
// One received byte is taken per transfer and a byte can be taken in every
// clock cycle: the parse state and the crc-16 byte step (poly 0x8005, init 0)
// are combinational, and the result goes into an output register backed
// by a one-entry skid stage. rx_stall_o rises only while that skid stage is
// occupied, i.e. after the result side has stalled with a result waiting and a
// second result has been produced. The receiver hunts for the header
// FF FF FD 00, reads the id and the little-endian length, checks the trailing
// little-endian crc and delivers one result per finished or dropped packet.
// Packets whose length plus seven exceeds MAX_PACKET_BYTES are dropped right
// after the length field with status too long; lengths below three give status
// too short. An accepted packet with id 1 to 16 sets bit id-1 of the present
// mask, which resets to 0x00FF. Byte stuffing is not removed.
module servo_status_packet_receiver #(
  parameter int unsigned MAX_PACKET_BYTES = sspr_pkg::MAX_PACKET_BYTES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // received byte channel
  input  logic                      rx_valid_i,
  output logic                      rx_stall_o,
  input  logic [7:0]                rx_byte_i,
  // packet result channel
  output logic                      status_valid_o,
  input  logic                      status_stall_i,
  output logic [2:0]                packet_status_o,
  output logic [7:0]                servo_id_o,
  output logic [7:0]                instruction_o,
  output logic [7:0]                servo_error_o,
  output logic                      newly_present_o,
  output logic [sspr_pkg::MASK_W-1:0] present_mask_o
);

  // byte position counter only needs to reach the last packet byte
  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES);

  localparam logic [CNT_W-1:0] POS_FIRST  = CNT_W'(sspr_pkg::POS_FIRST);
  localparam logic [CNT_W-1:0] POS_ID     = CNT_W'(sspr_pkg::POS_ID);
  localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(sspr_pkg::POS_LEN_LO);
  localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(sspr_pkg::POS_LEN_HI);
  localparam logic [CNT_W-1:0] POS_INS    = CNT_W'(sspr_pkg::POS_INS);
  localparam logic [CNT_W-1:0] POS_ERR    = CNT_W'(sspr_pkg::POS_ERR);

  typedef enum logic {
    PH_HUNT,
    PH_COLLECT
  } phase_e;

  // parse state
  phase_e                    phase_q, phase_d;
  logic [23:0]               win_q, win_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          last_q, last_d;     // position of the crc high byte
  logic [15:0]               crc_q, crc_d;
  logic [7:0]                len_lo_q, len_lo_d;
  logic [7:0]                held_id_q, held_id_d;
  logic [7:0]                held_ins_q, held_ins_d;
  logic [7:0]                held_err_q, held_err_d;
  logic [7:0]                crc_lo_q, crc_lo_d;
  logic [sspr_pkg::MASK_W-1:0] present_q, present_d;

  // combinational helpers
  logic                      rx_fire;
  logic                      res_valid;
  sspr_pkg::result_t         res;
  sspr_pkg::result_t         out_data;
  logic                      skid_full;
  logic [15:0]               body_len;
  logic [16:0]               total_len;
  logic [15:0]               rx_crc;
  logic [3:0]                id_idx;

  assign rx_fire   = rx_valid_i && !skid_full;
  assign body_len  = {rx_byte_i, len_lo_q};
  assign total_len = {1'b0, body_len} + 17'(sspr_pkg::PKT_OVERHEAD);
  assign rx_crc    = {rx_byte_i, crc_lo_q};
  assign id_idx    = 4'(held_id_q - 8'd1);

  always_comb begin
    phase_d    = phase_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    crc_d      = crc_q;
    len_lo_d   = len_lo_q;
    held_id_d  = held_id_q;
    held_ins_d = held_ins_q;
    held_err_d = held_err_q;
    crc_lo_d   = crc_lo_q;
    present_d  = present_q;

    res_valid         = 1'b0;
    res.status        = sspr_pkg::ST_OK;
    res.servo_id      = held_id_q;
    res.instruction   = 8'h00;
    res.servo_error   = 8'h00;
    res.newly_present = 1'b0;
    res.present_mask  = present_q;

    if (rx_fire) begin
      if (phase_q == PH_HUNT) begin
        // sliding header search
        if (win_q == sspr_pkg::HDR_WINDOW && rx_byte_i == sspr_pkg::HDR_LAST) begin
          crc_d   = sspr_pkg::CRC_HDR;
          cnt_d   = POS_FIRST;
          win_d   = '0;
          phase_d = PH_COLLECT;
        end else begin
          win_d = {win_q[15:0], rx_byte_i};
        end
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == POS_ID) begin
          held_id_d = rx_byte_i;
          crc_d     = sspr_pkg::crc_feed(crc_q, rx_byte_i);
        end else if (cnt_q == POS_LEN_LO) begin
          len_lo_d = rx_byte_i;
          crc_d    = sspr_pkg::crc_feed(crc_q, rx_byte_i);
        end else if (cnt_q == POS_LEN_HI) begin
          crc_d  = sspr_pkg::crc_feed(crc_q, rx_byte_i);
          last_d = CNT_W'(total_len - 17'd1);
          // length checks drop the packet before any body byte
          if (body_len < sspr_pkg::MIN_BODY_LEN) begin
            res_valid  = 1'b1;
            res.status = sspr_pkg::ST_TOO_SHORT;
          end else if (total_len > 17'(MAX_PACKET_BYTES)) begin
            res_valid  = 1'b1;
            res.status = sspr_pkg::ST_TOO_LONG;
          end
        end else begin
          if (cnt_q == POS_INS) begin
            held_ins_d = rx_byte_i;
          end
          if (cnt_q == POS_ERR) begin
            held_err_d = rx_byte_i;
          end
          if (cnt_q == last_q) begin
            // crc high byte closes the packet
            res_valid       = 1'b1;
            res.instruction = held_ins_q;
            res.servo_error = held_err_q;
            if (rx_crc != crc_q) begin
              res.status = sspr_pkg::ST_CRC_ERR;
            end else if (held_id_q == 8'd0 || held_id_q > 8'(sspr_pkg::MAX_SERVO_ID)) begin
              res.status = sspr_pkg::ST_BAD_ID;
            end else begin
              res.status = sspr_pkg::ST_OK;
              // ids above the mask width are not tracked; none pass the id check here
              if (held_id_q <= 8'(sspr_pkg::MASK_W) && !present_q[id_idx]) begin
                present_d[id_idx] = 1'b1;
                res.newly_present = 1'b1;
              end
            end
          end else if (cnt_q == last_q - CNT_W'(1)) begin
            crc_lo_d = rx_byte_i;
          end else begin
            crc_d = sspr_pkg::crc_feed(crc_q, rx_byte_i);
          end
        end
      end
    end

    res.present_mask = present_d;

    // any result sends the receiver back to hunting
    if (res_valid) begin
      phase_d = PH_HUNT;
      win_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      win_q     <= '0;
      cnt_q     <= '0;
      present_q <= sspr_pkg::MASK_RESET;
    end else begin
      phase_q   <= phase_d;
      win_q     <= win_d;
      cnt_q     <= cnt_d;
      present_q <= present_d;
    end
  end

  // payload state, only read after it has been written in the same packet
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    crc_q      <= crc_d;
    len_lo_q   <= len_lo_d;
    held_id_q  <= held_id_d;
    held_ins_q <= held_ins_d;
    held_err_q <= held_err_d;
    crc_lo_q   <= crc_lo_d;
  end

  // result register plus skid stage
  sspr_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (skid_full),
    .valid_o (status_valid_o),
    .stall_i (status_stall_i),
    .data_o  (out_data)
  );

  assign rx_stall_o      = skid_full;
  assign packet_status_o = out_data.status;
  assign servo_id_o      = out_data.servo_id;
  assign instruction_o   = out_data.instruction;
  assign servo_error_o   = out_data.servo_error;
  assign newly_present_o = out_data.newly_present;
  assign present_mask_o  = out_data.present_mask;

endmodule

FILE: hw/rtl/sspr_checker.sv
// ----------------------------------------------------------------------------
// sspr_checker
// port level checks of the status packet receiver
// ----------------------------------------------------------------------------
module sspr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rx_valid_i,
  input logic                        rx_stall_o,
  input logic [7:0]                  rx_byte_i,
  input logic                        status_valid_o,
  input logic                        status_stall_i,
  input logic [2:0]                  packet_status_o,
  input logic [7:0]                  servo_id_o,
  input logic [7:0]                  instruction_o,
  input logic [7:0]                  servo_error_o,
  input logic                        newly_present_o,
  input logic [sspr_pkg::MASK_W-1:0] present_mask_o
);

  // a stalled byte transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_stall_o |=> rx_valid_i && $stable(rx_byte_i))
    else $error("stalled byte changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o && status_stall_i |=> status_valid_o && $stable(packet_status_o)
      && $stable(servo_id_o) && $stable(instruction_o) && $stable(servo_error_o)
      && $stable(newly_present_o) && $stable(present_mask_o))
    else $error("stalled result changed");

  // only accepted packets can newly mark a servo present
  a_fresh_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o && newly_present_o |-> packet_status_o == sspr_pkg::ST_OK)
    else $error("newly present on a rejected packet");

  // a newly present servo has a tracked id and its bit is set
  a_fresh_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o && newly_present_o |-> servo_id_o != 8'd0
      && servo_id_o <= 8'(sspr_pkg::MASK_W)
      && present_mask_o[4'(servo_id_o - 8'd1)])
    else $error("newly present id inconsistent with mask");

  // reset bits of the mask are never cleared
  a_mask_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o |-> present_mask_o[7:0] == sspr_pkg::MASK_RESET[7:0])
    else $error("present mask lost a reset bit");

endmodule

bind servo_status_packet_receiver sspr_checker u_sspr_checker (.*);
